FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sidtoa_pkg.sv
package sidtoa_pkg;

    localparam int BIN_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_EMIT
    } t_state;

endpackage

FILE: rtl/sidtoa_dabble.sv
// One shift-and-add-3 step: every BCD digit of 5 or more gets 3 added,
// then the BCD and binary words shift left together by one bit.
module sidtoa_dabble
    import sidtoa_pkg::*;
(
    input  logic [BCD_W-1:0] i_bcd,
    input  logic [BIN_W-1:0] i_bin,
    output logic [BCD_W-1:0] o_bcd,
    output logic [BIN_W-1:0] o_bin
);

    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (i_bcd[k*DIGIT_W +: DIGIT_W] >= DIGIT_HALF) begin
                adj[k*DIGIT_W +: DIGIT_W] = i_bcd[k*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
            end else begin
                adj[k*DIGIT_W +: DIGIT_W] = i_bcd[k*DIGIT_W +: DIGIT_W];
            end
        end
    end

    assign o_bcd = {adj[BCD_W-2:0], i_bin[BIN_W-1]};
    assign o_bin = {i_bin[BIN_W-2:0], 1'b0};

endmodule

FILE: rtl/signed_int_to_decimal_ascii.sv
// Flow: accept, double-dabble conversion, a leading minus if negative, zero skip, then digits.
// One value at a time: o_ready is high only in idle, so a new value waits until the last digit
//   is in the output register. Steps: accept, 32 double-dabble steps on the single shared
//   add-3/shift unit, the sign for negative values, skip of leading zeros, then the digits.
// Reset: i_rst_n synchronous, active low; returns to idle, output empty.
module signed_int_to_decimal_ascii
    import sidtoa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [BIN_W-1:0] i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHAR_W-1:0]     o_character,
    output logic                  o_last
);

`include "assert_macros.svh"

    localparam int STEP_W = $clog2(BIN_W);
    localparam int DCNT_W = $clog2(NUM_DIGITS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BIN_W - 1);
    localparam logic [DCNT_W-1:0] DCNT_FULL = DCNT_W'(NUM_DIGITS);
    localparam logic [DCNT_W-1:0] DCNT_ONE  = DCNT_W'(1);

    t_state r_state, n_state;

    logic                r_neg, n_neg;
    logic [BIN_W-1:0]    r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;
    logic                r_ovalid, n_ovalid;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic [BCD_W-1:0]    step_bcd;
    logic [BIN_W-1:0]    step_bin;
    logic [DIGIT_W-1:0]  top_digit;
    logic                take_in;
    logic                out_free;   // output register can take a new beat

    // Shared conversion unit
    sidtoa_dabble u_dabble (
        .i_bcd (r_bcd),
        .i_bin (r_bin),
        .o_bcd (step_bcd),
        .o_bin (step_bin)
    );

    assign top_digit = r_bcd[BCD_W-1 -: DIGIT_W];
    assign take_in   = i_valid && o_ready;
    assign out_free  = !r_ovalid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CONV;
            end
            S_CONV: begin
                if (r_step == STEP_LAST) n_state = r_neg ? S_SIGN : S_SKIP;
            end
            S_SIGN: begin
                if (out_free) n_state = S_SKIP;
            end
            S_SKIP: begin
                // stop at the first non-zero digit, or the units digit
                if (top_digit != '0 || r_dcnt == DCNT_ONE) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free && r_dcnt == DCNT_ONE) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and output register
    always_comb begin
        o_ready  = (r_state == S_IDLE);
        n_neg    = r_neg;
        n_bin    = r_bin;
        n_bcd    = r_bcd;
        n_step   = r_step;
        n_dcnt   = r_dcnt;
        n_ovalid = r_ovalid && !i_ready;
        n_char   = r_char;
        n_last   = r_last;
        case (r_state)
            S_IDLE: begin
                if (take_in) begin
                    n_neg  = i_value[BIN_W-1];
                    // magnitude as unsigned: the most negative value works too
                    n_bin  = i_value[BIN_W-1] ? (BIN_W'(0) - BIN_W'(i_value))
                                              : BIN_W'(i_value);
                    n_bcd  = '0;
                    n_step = '0;
                    n_dcnt = DCNT_FULL;
                end
            end
            S_CONV: begin
                n_bcd  = step_bcd;
                n_bin  = step_bin;
                n_step = r_step + STEP_W'(1);
            end
            S_SIGN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_MINUS;
                    n_last   = 1'b0;
                end
            end
            S_SKIP: begin
                if (top_digit == '0 && r_dcnt != DCNT_ONE) begin
                    n_bcd  = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_dcnt = r_dcnt - DCNT_ONE;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_ZERO + CHAR_W'(top_digit);
                    n_last   = (r_dcnt == DCNT_ONE);
                    n_bcd    = {r_bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_dcnt   = r_dcnt - DCNT_ONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_step   <= '0;
            r_dcnt   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_step   <= n_step;
            r_dcnt   <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_ovalid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // A fresh beat starts conversion from a clean step count
    `ASSERT_NXT(a_start_conv, take_in, r_state == S_CONV && r_step == '0,
                "conversion did not start after input beat")
    // Every emitted digit is a proper decimal digit
    `ASSERT_IMP(a_digit_range, r_state == S_EMIT, top_digit <= DIGIT_MAX,
                "BCD digit out of range")
    // Output carries only minus or a digit
    `ASSERT_IMP(a_char_set, o_valid,
                o_character == CHAR_MINUS ||
                (o_character >= CHAR_ZERO && o_character <= CHAR_ZERO + CHAR_W'(DIGIT_MAX)),
                "illegal output character")
    // The sign never closes a number
    `ASSERT_IMP(a_sign_not_last, o_valid && o_character == CHAR_MINUS, !o_last,
                "minus sign flagged last")

endmodule
